>>> rtl/core/etm_pkg.sv
// etm_pkg: shared types, constants and arithmetic helpers of the
// Euler transform matrix pipeline. No dependencies.
`timescale 1ns / 1ps
package etm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int PHASE_SHIFT  = 32 - ANGLE_BITS;
  localparam int CORDIC_STEPS = 16;
  localparam int CX_W         = 34;
  localparam int CZ_W         = 32;
  localparam int P2_W         = 17;
  localparam int R_W          = 18;
  localparam int PROD_W       = 32 + R_W;
  localparam int SC_LAT       = CORDIC_STEPS + 2;
  localparam int ROT_LAT      = 2;
  localparam int SIDE_DEPTH   = SC_LAT + ROT_LAT;
  localparam int PIPE_DEPTH   = SIDE_DEPTH + 2;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);
  localparam logic signed [CX_W-1:0] ROUND_HALF  = CX_W'(16384);

  localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef enum logic {
    ORDER_YXZ = 1'b0,
    ORDER_ZXY = 1'b1
  } order_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
  } out_t;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } sc_t;

  typedef struct packed {
    logic [1:0]              quad;
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [CZ_W-1:0]  z;
  } cordic_t;

  typedef logic signed [R_W-1:0] rent_t;
  typedef rent_t [8:0] rot_t;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } side_t;

  // One micro-rotation of the CORDIC in rotation mode
  function automatic cordic_t cordic_step(cordic_t s, int i);
    cordic_t r;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    r  = s;
    dx = s.y >>> i;
    dy = s.x >>> i;
    if (s.z >= 0) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - ATAN_TURN[i];
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + ATAN_TURN[i];
    end
    return r;
  endfunction

  // Round Q30 to Q15 and clamp to 16 bits
  function automatic logic signed [15:0] round_q15(logic signed [CX_W-1:0] v);
    logic signed [CX_W-1:0] t;
    t = (v + ROUND_HALF) >>> 15;
    if (t > CX_W'(32767)) return 16'sd32767;
    if (t < -CX_W'(32768)) return -16'sd32768;
    return t[15:0];
  endfunction

endpackage

>>> rtl/core/etm_sincos.sv
// etm_sincos: pipelined CORDIC giving cosine and sine of one binary angle
// in Q1.15. Depends on etm_pkg.
`timescale 1ns / 1ps
module etm_sincos import etm_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output sc_t                sc
);

  cordic_t    stage [CORDIC_STEPS+1];
  logic [31:0] phase;

  // Map the angle onto a 32-bit turn
  assign phase = {{16{angle[15]}}, angle} << PHASE_SHIFT;

  // Load the first stage: quadrant and remaining phase
  always_ff @(posedge clk) begin
    if (en) begin
      stage[0].quad <= phase[31:30];
      stage[0].x    <= CORDIC_GAIN;
      stage[0].y    <= '0;
      stage[0].z    <= CZ_W'({2'b00, phase[29:0]});
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        stage[i+1] <= cordic_step(stage[i], i);
      end
    end
  end

  // Round and fold back into the quadrant
  always_ff @(posedge clk) begin
    logic signed [15:0] cq;
    logic signed [15:0] sq;
    cq = round_q15(stage[CORDIC_STEPS].x);
    sq = round_q15(stage[CORDIC_STEPS].y);
    if (en) begin
      unique case (stage[CORDIC_STEPS].quad)
        2'd0: begin sc.cos_v <= cq;  sc.sin_v <= sq;  end
        2'd1: begin sc.cos_v <= -sq; sc.sin_v <= cq;  end
        2'd2: begin sc.cos_v <= -cq; sc.sin_v <= -sq; end
        2'd3: begin sc.cos_v <= sq;  sc.sin_v <= -cq; end
      endcase
    end
  end

endmodule

>>> rtl/core/etm_rot.sv
// etm_rot: two-stage rotation matrix builder from three sine/cosine pairs,
// YXZ or ZXY order. Depends on etm_pkg.
`timescale 1ns / 1ps
module etm_rot import etm_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  order_t mode,
  input  sc_t    scx,
  input  sc_t    scy,
  input  sc_t    scz,
  output rot_t   rot
);

  typedef logic signed [P2_W-1:0] p2_t;

  function automatic p2_t mq2(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    return p[31:15];
  endfunction

  function automatic rent_t mq3(p2_t a, logic signed [15:0] b);
    logic signed [P2_W+15:0] p;
    p = a * b;
    return p[P2_W+15:15];
  endfunction

  function automatic rent_t ext(p2_t a);
    return {a[P2_W-1], a};
  endfunction

  p2_t cycz, sysx, cysx, czsy, cxsz, cxcz, cxsy, cycx, sysz, czsx, szsx, cysz;
  logic signed [15:0] sx, sy, sz;

  // Form the pairwise products
  always_ff @(posedge clk) begin
    if (en) begin
      cycz <= mq2(scy.cos_v, scz.cos_v);
      sysx <= mq2(scy.sin_v, scx.sin_v);
      cysx <= mq2(scy.cos_v, scx.sin_v);
      czsy <= mq2(scz.cos_v, scy.sin_v);
      cxsz <= mq2(scx.cos_v, scz.sin_v);
      cxcz <= mq2(scx.cos_v, scz.cos_v);
      cxsy <= mq2(scx.cos_v, scy.sin_v);
      cycx <= mq2(scy.cos_v, scx.cos_v);
      sysz <= mq2(scy.sin_v, scz.sin_v);
      czsx <= mq2(scz.cos_v, scx.sin_v);
      szsx <= mq2(scz.sin_v, scx.sin_v);
      cysz <= mq2(scy.cos_v, scz.sin_v);
      sx   <= scx.sin_v;
      sy   <= scy.sin_v;
      sz   <= scz.sin_v;
    end
  end

  // Finish the triple products and sum per the selected order
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (mode)
        ORDER_YXZ: begin
          rot[0] <= ext(cycz) + mq3(sysx, sz);
          rot[1] <= ext(cxsz);
          rot[2] <= mq3(cysx, sz) - ext(czsy);
          rot[3] <= mq3(czsy, sx) - ext(cysz);
          rot[4] <= ext(cxcz);
          rot[5] <= mq3(cycz, sx) + ext(sysz);
          rot[6] <= ext(cxsy);
          rot[7] <= -R_W'(sx);
          rot[8] <= ext(cycx);
        end
        ORDER_ZXY: begin
          rot[0] <= ext(cycz) - mq3(szsx, sy);
          rot[1] <= ext(cysz) + mq3(czsx, sy);
          rot[2] <= -ext(cxsy);
          rot[3] <= -ext(cxsz);
          rot[4] <= ext(cxcz);
          rot[5] <= R_W'(sx);
          rot[6] <= ext(czsy) + mq3(cysz, sx);
          rot[7] <= ext(sysz) - mq3(cycz, sx);
          rot[8] <= ext(cycx);
        end
      endcase
    end
  end

endmodule

>>> rtl/core/etm_scale.sv
// etm_scale: scales each rotation row, truncates and saturates to
// Q16.16, and carries the translation along. Depends on etm_pkg.
`timescale 1ns / 1ps
module etm_scale import etm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  rot_t  rot,
  input  side_t side,
  output out_t  res
);

  logic signed [PROD_W-1:0] prod [9];
  logic signed [31:0]       m    [9];
  logic signed [31:0]       tx, ty, tz;
  logic signed [31:0]       otx, oty, otz;
  logic signed [31:0]       scl  [3];

  assign scl[0] = side.scale_x;
  assign scl[1] = side.scale_y;
  assign scl[2] = side.scale_z;

  // Multiply each entry by its row's scale
  for (genvar k = 0; k < 9; k++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        prod[k] <= scl[k/3] * rot[k];
      end
    end
  end

  // Carry the translation through both stages
  always_ff @(posedge clk) begin
    if (en) begin
      tx  <= side.trans_x;
      ty  <= side.trans_y;
      tz  <= side.trans_z;
      otx <= tx;
      oty <= ty;
      otz <= tz;
    end
  end

  // Drop the extra fraction bits and clamp to 32 bits
  for (genvar k = 0; k < 9; k++) begin : g_sat
    logic signed [PROD_W-16:0] v;
    assign v = prod[k][PROD_W-1:15];
    always_ff @(posedge clk) begin
      if (en) begin
        if (v[PROD_W-16:31] != {(PROD_W-46){v[31]}}) begin
          m[k] <= v[PROD_W-16] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
          m[k] <= v[31:0];
        end
      end
    end
  end

  assign res.m00    = m[0];
  assign res.m01    = m[1];
  assign res.m02    = m[2];
  assign res.m10    = m[3];
  assign res.m11    = m[4];
  assign res.m12    = m[5];
  assign res.m20    = m[6];
  assign res.m21    = m[7];
  assign res.m22    = m[8];
  assign res.out_tx = otx;
  assign res.out_ty = oty;
  assign res.out_tz = otz;

endmodule

>>> rtl/core/euler_transform_matrix_top.sv
// Throughput: one request per cycle while the output is not stalled; the
// angle load stage, 16 CORDIC stages, the rounding stage, two rotation and
// two scale stages advance together.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (rst, synchronous) clears all valid bits and sets order to YXZ.
// Depends on etm_pkg, etm_sincos, etm_rot, etm_scale.
`timescale 1ns / 1ps
module euler_transform_matrix_top import etm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic [PIPE_DEPTH:1] vld;
  logic                adv;
  order_t              order_mode;
  side_t               side [SIDE_DEPTH];
  sc_t                 sc_x, sc_y, sc_z;
  rot_t                rot;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[PIPE_DEPTH];
  assign cfg_ready = 1'b1;

  // Hold the rotation order
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= ORDER_YXZ;
    end else if (cfg_valid) begin
      order_mode <= order_t'(cfg_data);
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-1:1], in_valid};
    end
  end

  // Delay scale and translation to meet the rotation entries
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{scale_x: in_data.scale_x, scale_y: in_data.scale_y,
                   scale_z: in_data.scale_z, trans_x: in_data.trans_x,
                   trans_y: in_data.trans_y, trans_z: in_data.trans_z};
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  etm_sincos u_sc_x (.clk(clk), .en(adv), .angle(in_data.angle_x), .sc(sc_x));
  etm_sincos u_sc_y (.clk(clk), .en(adv), .angle(in_data.angle_y), .sc(sc_y));
  etm_sincos u_sc_z (.clk(clk), .en(adv), .angle(in_data.angle_z), .sc(sc_z));

  etm_rot u_rot (
    .clk (clk),
    .en  (adv),
    .mode(order_mode),
    .scx (sc_x),
    .scy (sc_y),
    .scz (sc_z),
    .rot (rot)
  );

  etm_scale u_scale (
    .clk (clk),
    .en  (adv),
    .rot (rot),
    .side(side[SIDE_DEPTH-1]),
    .res (out_data)
  );

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("valid bits set after reset");

  // A stalled output freezes every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vld))
    else $error("pipeline moved during stall");

  // X-axis cosine of a valid item never reaches the negative bound
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    vld[SC_LAT] |-> sc_x.cos_v != -16'sd32768)
    else $error("cosine out of range");

endmodule
